### hw/rtl/upq_pkg.sv
// ----------------------------------------------------------------------------
// upq_pkg
// Types and codes shared by the unsorted priority queue core.
// ----------------------------------------------------------------------------
package upq_pkg;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_PULL   = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic               command;
      logic signed [31:0] item_value;
      logic signed [31:0] item_priority;
   } upq_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] pulled_value;
      logic signed [31:0] pulled_priority;
      logic signed [31:0] top_value;
      logic signed [31:0] top_priority;
      logic               top_valid;
      logic [4:0]         entry_count;
      logic               is_full;
   } upq_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } upq_state_type;

endpackage

### hw/rtl/upq_store.sv
// ----------------------------------------------------------------------------
// upq_store
// Entry store: value and priority arrays, one write port, one registered read.
// ----------------------------------------------------------------------------
module upq_store #(
   parameter int DEPTH     = 16,
   parameter int DATA_BITS = 32,
   parameter int IDX_BITS  = 4
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_BITS-1:0]         wr_addr,
   input  logic signed [DATA_BITS-1:0] wr_value,
   input  logic signed [DATA_BITS-1:0] wr_priority,
   input  logic [IDX_BITS-1:0]         rd_addr,
   output logic signed [DATA_BITS-1:0] rd_value,
   output logic signed [DATA_BITS-1:0] rd_priority
);

   logic signed [DATA_BITS-1:0] value_mem [DEPTH];
   logic signed [DATA_BITS-1:0] priority_mem [DEPTH];
   logic signed [DATA_BITS-1:0] rd_value_ff;
   logic signed [DATA_BITS-1:0] rd_priority_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr]    <= wr_value;
         priority_mem[wr_addr] <= wr_priority;
      end
   end

   always_ff @(posedge clock) begin
      rd_value_ff    <= value_mem[rd_addr];
      rd_priority_ff <= priority_mem[rd_addr];
   end

   assign rd_value    = rd_value_ff;
   assign rd_priority = rd_priority_ff;

endmodule

### hw/rtl/unsorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// unsorted_priority_queue_core
// Priority queue kept as an unsorted array in arrival order.
// ----------------------------------------------------------------------------
// An insert writes the pair at the tail and updates the top entry register by
// one compare. A pull sweeps the store through its single read port, one
// entry per cycle, closing the gap behind the removed entry with the write
// port while the shared compare picks the new top (earliest wins on a tie).
// A refused insert or a pull on an empty queue goes straight to its result.
// The input is not ready while a transfer is being worked on; a finished
// result waits in the output register while the next transfer is taken.
module unsorted_priority_queue_core #(
   parameter int DEPTH     = 16,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  upq_pkg::upq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output upq_pkg::upq_rsp_type rsp_data
);

   import upq_pkg::*;

   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   upq_state_type state_ff, state_in;

   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic [IDX_BITS-1:0]         top_idx_ff, top_idx_in;
   logic signed [DATA_BITS-1:0] top_val_ff, top_val_in;
   logic signed [DATA_BITS-1:0] top_pri_ff, top_pri_in;
   logic [IDX_BITS-1:0]         rd_addr_ff, rd_addr_in;
   logic [IDX_BITS-1:0]         rd_idx_ff, rd_idx_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic                        best_found_ff, best_found_in;
   logic [IDX_BITS-1:0]         best_idx_ff, best_idx_in;
   logic signed [DATA_BITS-1:0] best_val_ff, best_val_in;
   logic signed [DATA_BITS-1:0] best_pri_ff, best_pri_in;
   logic signed [DATA_BITS-1:0] pulled_val_ff, pulled_val_in;
   logic signed [DATA_BITS-1:0] pulled_pri_ff, pulled_pri_in;
   logic [1:0]                  status_ff, status_in;
   upq_rsp_type                 rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        wr_en;
   logic [IDX_BITS-1:0]         wr_addr;
   logic signed [DATA_BITS-1:0] wr_value;
   logic signed [DATA_BITS-1:0] wr_priority;
   logic signed [DATA_BITS-1:0] rd_value;
   logic signed [DATA_BITS-1:0] rd_priority;

   logic signed [DATA_BITS-1:0] new_val;
   logic signed [DATA_BITS-1:0] new_pri;
   logic signed [DATA_BITS-1:0] cmp_lhs;
   logic signed [DATA_BITS-1:0] cmp_rhs;
   logic                        cmp_gt;
   logic [IDX_BITS-1:0]         last_idx;
   logic [IDX_BITS-1:0]         cand_idx;
   logic                        full;
   logic                        req_fire;

   upq_store #(
      .DEPTH     (DEPTH),
      .DATA_BITS (DATA_BITS),
      .IDX_BITS  (IDX_BITS)
   ) u_store (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_value    (wr_value),
      .wr_priority (wr_priority),
      .rd_addr     (rd_addr_ff),
      .rd_value    (rd_value),
      .rd_priority (rd_priority)
   );

   assign new_val  = DATA_BITS'(req_data.item_value);
   assign new_pri  = DATA_BITS'(req_data.item_priority);
   // one compare: sweep data against the best so far, else new pair against top
   assign cmp_lhs  = rd_pend_ff ? rd_priority : new_pri;
   assign cmp_rhs  = rd_pend_ff ? best_pri_ff : top_pri_ff;
   assign cmp_gt   = (cmp_lhs > cmp_rhs);
   assign last_idx = IDX_BITS'(count_ff - 1'b1);
   assign cand_idx = (rd_idx_ff > top_idx_ff) ? rd_idx_ff - 1'b1 : rd_idx_ff;
   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_idx_ff    <= top_idx_in;
      top_val_ff    <= top_val_in;
      top_pri_ff    <= top_pri_in;
      rd_addr_ff    <= rd_addr_in;
      rd_idx_ff     <= rd_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      best_pri_ff   <= best_pri_in;
      pulled_val_ff <= pulled_val_in;
      pulled_pri_ff <= pulled_pri_in;
      status_ff     <= status_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_idx_in    = top_idx_ff;
      top_val_in    = top_val_ff;
      top_pri_in    = top_pri_ff;
      rd_addr_in    = rd_addr_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pend_in    = 1'b0;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      best_pri_in   = best_pri_ff;
      pulled_val_in = pulled_val_ff;
      pulled_pri_in = pulled_pri_ff;
      status_in     = status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_BITS-1:0];
      wr_value      = new_val;
      wr_priority   = new_pri;

      // sweep: close the gap and pick the new top from arriving read data
      if (rd_pend_ff && rd_idx_ff != top_idx_ff) begin
         if (rd_idx_ff > top_idx_ff) begin
            wr_en       = 1'b1;
            wr_addr     = cand_idx;
            wr_value    = rd_value;
            wr_priority = rd_priority;
         end
         if (!best_found_ff || cmp_gt) begin
            best_found_in = 1'b1;
            best_idx_in   = cand_idx;
            best_val_in   = rd_value;
            best_pri_in   = rd_priority;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pulled_val_in = '0;
               pulled_pri_in = '0;
               status_in     = STATUS_OK;
               state_in      = ST_FINISH;
               if (req_data.command == CMD_INSERT) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (count_ff == '0 || cmp_gt) begin
                        top_idx_in = count_ff[IDX_BITS-1:0];
                        top_val_in = new_val;
                        top_pri_in = new_pri;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     pulled_val_in = top_val_ff;
                     pulled_pri_in = top_pri_ff;
                     rd_addr_in    = '0;
                     best_found_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            rd_idx_in  = rd_addr_ff;
            rd_addr_in = rd_addr_ff + 1'b1;
            if (rd_addr_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            count_in   = count_ff - 1'b1;
            top_idx_in = best_idx_in;
            top_val_in = best_val_in;
            top_pri_in = best_pri_in;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status          = status_ff;
               rsp_in.pulled_value    = 32'(pulled_val_ff);
               rsp_in.pulled_priority = 32'(pulled_pri_ff);
               rsp_in.top_valid       = (count_ff != '0);
               rsp_in.top_value       = (count_ff != '0) ? 32'(top_val_ff) : '0;
               rsp_in.top_priority    = (count_ff != '0) ? 32'(top_pri_ff) : '0;
               rsp_in.entry_count     = 5'(count_ff);
               rsp_in.is_full         = full;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count above depth");

   a_pull_scans: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command == CMD_PULL && count_ff != '0)
      |=> state_ff == ST_SCAN)
      else $error("pull on nonempty queue did not start sweep");

   a_drain_dec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pull did not remove one entry");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FULL) |-> rsp_ff.is_full)
      else $error("refused insert while not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_EMPTY) |-> !rsp_ff.top_valid)
      else $error("empty pull reports a top entry");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for unsorted_priority_queue_core. A directed table
// covers the empty, full and tie cases and the extremes of value and
// priority. Random traffic with bursty input and a stalling output follows.
// Each result transfer is checked field by field against the fixed result of
// its directed row, or else against a shadow queue kept in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   import upq_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic signed [31:0] V_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] V_MIN = 32'sh80000000;

   typedef struct {
      upq_req_type req;
      bit          has_fixed;
      upq_rsp_type fixed;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   upq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   upq_rsp_type rsp_data;

   logic signed [31:0] shadow_value [QUEUE_DEPTH];
   logic signed [31:0] shadow_priority [QUEUE_DEPTH];
   int                 shadow_count = 0;

   upq_rsp_type  pending_results [$];
   stim_row_type directed_rows [$];
   upq_rsp_type  expected_rsp;
   int           fail_count = 0;
   int           stall_cycles = 0;
   int           burst_left = 0;
   bit           holdoff_request = 1'b0;

   unsorted_priority_queue_core #(
      .DEPTH    (QUEUE_DEPTH),
      .DATA_BITS(32)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // earliest entry wins on equal priority
   function automatic int top_slot();
      int best;
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
         if (shadow_priority[i] > shadow_priority[best]) best = i;
      end
      return best;
   endfunction

   function automatic upq_rsp_type apply_queue_op(upq_req_type r);
      upq_rsp_type o;
      int          slot;
      o = '0;
      if (r.command == CMD_INSERT) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            shadow_value[shadow_count]    = r.item_value;
            shadow_priority[shadow_count] = r.item_priority;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         o.status = STATUS_EMPTY;
      end else begin
         slot = top_slot();
         o.pulled_value    = shadow_value[slot];
         o.pulled_priority = shadow_priority[slot];
         for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_value[i]    = shadow_value[i + 1];
            shadow_priority[i] = shadow_priority[i + 1];
         end
         shadow_count--;
      end
      if (shadow_count > 0) begin
         slot = top_slot();
         o.top_value    = shadow_value[slot];
         o.top_priority = shadow_priority[slot];
         o.top_valid    = 1'b1;
      end
      o.entry_count = 5'(shadow_count);
      o.is_full     = (shadow_count == QUEUE_DEPTH);
      return o;
   endfunction

   function automatic upq_req_type make_req(logic cmd, logic signed [31:0] v,
                                            logic signed [31:0] p);
      upq_req_type r;
      r.command       = cmd;
      r.item_value    = v;
      r.item_priority = p;
      return r;
   endfunction

   function automatic upq_rsp_type make_rsp(logic [1:0] st, logic signed [31:0] pv,
                                            logic signed [31:0] pp,
                                            logic signed [31:0] tv,
                                            logic signed [31:0] tp, logic vld,
                                            logic [4:0] cnt, logic full);
      upq_rsp_type o;
      o.status          = st;
      o.pulled_value    = pv;
      o.pulled_priority = pp;
      o.top_value       = tv;
      o.top_priority    = tp;
      o.top_valid       = vld;
      o.entry_count     = cnt;
      o.is_full         = full;
      return o;
   endfunction

   function automatic stim_row_type plain_row(upq_req_type r);
      stim_row_type row;
      row.req       = r;
      row.has_fixed = 1'b0;
      row.fixed     = '0;
      return row;
   endfunction

   function automatic stim_row_type fixed_row(upq_req_type r, upq_rsp_type o);
      stim_row_type row;
      row.req       = r;
      row.has_fixed = 1'b1;
      row.fixed     = o;
      return row;
   endfunction

   function automatic upq_req_type random_request(int insert_pct);
      upq_req_type r;
      r.command    = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_PULL;
      r.item_value = $urandom();
      case ($urandom_range(0, 5))
         0, 1: begin
            r.item_priority = $urandom();
         end
         2: begin
            r.item_priority = $urandom_range(0, 1) ? V_MAX : V_MIN;
         end
         default: begin
            r.item_priority = $urandom_range(0, 6);
            r.item_priority = r.item_priority - 3;
         end
      endcase
      return r;
   endfunction

   task automatic send_item(stim_row_type row);
      upq_rsp_type predicted;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_data  <= row.req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_queue_op(row.req);
      pending_results.push_back(row.has_fixed ? row.fixed : predicted);
      burst_left--;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s: expected %0h, actual %0h", name, expv, actv);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no expected result pending");
            fail_count++;
         end else begin
            expected_rsp = pending_results.pop_front();
            check_field("status", expected_rsp.status, rsp_data.status);
            check_field("pulled_value", expected_rsp.pulled_value, rsp_data.pulled_value);
            check_field("pulled_priority", expected_rsp.pulled_priority,
                        rsp_data.pulled_priority);
            check_field("top_value", expected_rsp.top_value, rsp_data.top_value);
            check_field("top_priority", expected_rsp.top_priority, rsp_data.top_priority);
            check_field("top_valid", expected_rsp.top_valid, rsp_data.top_valid);
            check_field("entry_count", expected_rsp.entry_count, rsp_data.entry_count);
            check_field("is_full", expected_rsp.is_full, rsp_data.is_full);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver back-pressure
   initial begin
      int mode;
      int seg_len;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_request = 1'b0;
         end else begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 150);
            for (int k = 0; k < seg_len && !holdoff_request; k++) begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= (k % 4 == 0);
                  default: rsp_ready <= ($urandom_range(0, 7) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int insert_pct;
      int seg;
      int item_total;
      directed_rows.push_back(fixed_row(make_req(CMD_PULL, V_MAX, V_MAX),
         make_rsp(STATUS_EMPTY, 0, 0, 0, 0, 1'b0, 5'd0, 1'b0)));
      directed_rows.push_back(fixed_row(make_req(CMD_INSERT, V_MAX, V_MIN),
         make_rsp(STATUS_OK, 0, 0, V_MAX, V_MIN, 1'b1, 5'd1, 1'b0)));
      directed_rows.push_back(fixed_row(make_req(CMD_INSERT, V_MIN, V_MAX),
         make_rsp(STATUS_OK, 0, 0, V_MIN, V_MAX, 1'b1, 5'd2, 1'b0)));
      // tie on priority: the older entry stays on top
      directed_rows.push_back(fixed_row(make_req(CMD_INSERT, 0, V_MAX),
         make_rsp(STATUS_OK, 0, 0, V_MIN, V_MAX, 1'b1, 5'd3, 1'b0)));
      directed_rows.push_back(fixed_row(make_req(CMD_PULL, 0, 0),
         make_rsp(STATUS_OK, V_MIN, V_MAX, 0, V_MAX, 1'b1, 5'd2, 1'b0)));
      directed_rows.push_back(plain_row(make_req(CMD_INSERT, -1, -1)));
      for (int i = 0; i < 13; i++) begin
         directed_rows.push_back(plain_row(make_req(CMD_INSERT, i * 7919 - 50000,
                                                    (i % 4) - 2)));
      end
      directed_rows.push_back(plain_row(make_req(CMD_INSERT, V_MAX, V_MAX)));
      repeat (3) directed_rows.push_back(plain_row(make_req(CMD_PULL, -1, V_MIN)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);
      wait_for_drain();

      item_total = 0;
      while (item_total < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: insert_pct = 80;
            1: insert_pct = 25;
            default: insert_pct = 55;
         endcase
         seg = $urandom_range(30, 120);
         for (int k = 0; k < seg && item_total < RANDOM_ITEMS; k++) begin
            send_item(plain_row(random_request(insert_pct)));
            item_total++;
            if (item_total == 500 || item_total == 1100) holdoff_request = 1'b1;
            if (item_total % 400 == 0) wait_for_drain();
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
